// ===== hw/rtl/jtag_master_tap_sequencer_unit_macros.svh =====
// Assertion macros for the JTAG master TAP sequencer.
// Included by jtms_dp under hw/rtl; relies on signals named clock and reset.
`ifndef JTAG_MASTER_TAP_SEQUENCER_UNIT_MACROS_SVH
`define JTAG_MASTER_TAP_SEQUENCER_UNIT_MACROS_SVH
`ifndef SYNTH
// Check a property in the same cycle.
`define JTMS_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("jtms: same-cycle check failed");
// Check a property in the next cycle.
`define JTMS_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("jtms: next-cycle check failed");
`else
`define JTMS_ASSERT_NOW(label, ante, cons)
`define JTMS_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ===== hw/rtl/jtms_pkg.sv =====
// Shared types, constants and TAP tables for the JTAG master TAP sequencer.
// No dependencies; used by every other file of the block but the macro header.
package jtms_pkg;

   localparam int IR_LENGTH      = 6;
   localparam int MAX_SHIFT_BITS = 32;
   localparam int RESET_TICKS    = 5;
   localparam int MAX_IDLE       = 48;

   localparam int OP_W   = 3;
   localparam int TAP_W  = 4;
   localparam int CNT_W  = 6;
   localparam int DATA_W = 32;
   localparam int UPC_W  = 4;
   localparam int PATH_W = 8;

   // Command codes
   localparam logic [OP_W-1:0] OP_RESET    = 3'd0;
   localparam logic [OP_W-1:0] OP_GOTO     = 3'd1;
   localparam logic [OP_W-1:0] OP_RUN      = 3'd2;
   localparam logic [OP_W-1:0] OP_SHIFT_IR = 3'd3;
   localparam logic [OP_W-1:0] OP_WRITE_DR = 3'd4;
   localparam logic [OP_W-1:0] OP_READ_DR  = 3'd5;

   // TAP state codes used by the sequencer
   localparam logic [TAP_W-1:0] TAP_TLR = 4'd0;
   localparam logic [TAP_W-1:0] TAP_RTI = 4'd1;
   localparam logic [TAP_W-1:0] TAP_SDR = 4'd4;
   localparam logic [TAP_W-1:0] TAP_SIR = 4'd11;

   // Microcode entry points
   localparam logic [UPC_W-1:0] UPC_RESET    = 4'd0;
   localparam logic [UPC_W-1:0] UPC_DONE     = 4'd1;
   localparam logic [UPC_W-1:0] UPC_GOTO     = 4'd2;
   localparam logic [UPC_W-1:0] UPC_RUN      = 4'd4;
   localparam logic [UPC_W-1:0] UPC_SHIFT_IR = 4'd8;
   localparam logic [UPC_W-1:0] UPC_SHIFT_DR = 4'd12;

   typedef enum logic [1:0] {UOP_WALK, UOP_CLOCK, UOP_SHIFT, UOP_DONE} uop_kind_type;
   typedef enum logic [1:0] {DST_TARGET, DST_RTI, DST_SIR, DST_SDR} dst_sel_type;
   typedef enum logic [1:0] {CNT_RESET, CNT_IDLE, CNT_IR, CNT_BITS} cnt_sel_type;
   typedef enum logic [1:0] {SEQ_IDLE, SEQ_LOAD, SEQ_STEP, SEQ_FINISH} seq_state_type;

   typedef struct packed {
      uop_kind_type kind;
      dst_sel_type  dst;
      cnt_sel_type  cnt;
      logic         tms;
   } uword_type;

   typedef struct packed {
      logic [OP_W-1:0]  op;
      logic [TAP_W-1:0] target;
      logic [CNT_W-1:0] idle;
      logic [CNT_W-1:0] nbits;
   } cmd_type;

   typedef struct packed {
      logic tick;
      logic tms;
      logic use_data;
      logic finish;
   } ctrl_type;

   typedef struct packed {
      logic             room_tick;
      logic             room_out;
      logic [TAP_W-1:0] tap;
   } dp_status_type;

   typedef struct packed {
      logic              tick_valid;
      logic              tms_level;
      logic              tdi_level;
      logic              last;
      logic [DATA_W-1:0] captured_bits;
      logic [TAP_W-1:0]  tap_now;
   } rsp_payload_type;

   // Next TAP state, [state][tms]
   localparam logic [TAP_W-1:0] TAP_NEXT [16][2] = '{
      '{4'd1, 4'd0},   '{4'd1, 4'd2},   '{4'd3, 4'd9},   '{4'd4, 4'd5},
      '{4'd4, 4'd5},   '{4'd6, 4'd8},   '{4'd6, 4'd7},   '{4'd4, 4'd8},
      '{4'd1, 4'd2},   '{4'd10, 4'd0},  '{4'd11, 4'd12}, '{4'd11, 4'd12},
      '{4'd13, 4'd15}, '{4'd13, 4'd14}, '{4'd11, 4'd15}, '{4'd1, 4'd2}
   };

   // Shortest-path TMS bits, LSB first, [from][to]
   localparam logic [PATH_W-1:0] PATH_BITS [16][16] = '{
      '{8'h00,8'h00,8'h02,8'h02,8'h02,8'h0A,8'h0A,8'h2A,
        8'h1A,8'h06,8'h06,8'h06,8'h16,8'h16,8'h56,8'h36},
      '{8'h07,8'h00,8'h01,8'h01,8'h01,8'h05,8'h05,8'h15,
        8'h0D,8'h03,8'h03,8'h03,8'h0B,8'h0B,8'h2B,8'h1B},
      '{8'h03,8'h03,8'h00,8'h00,8'h00,8'h02,8'h02,8'h0A,
        8'h06,8'h01,8'h01,8'h01,8'h05,8'h05,8'h15,8'h0D},
      '{8'h1F,8'h03,8'h07,8'h00,8'h00,8'h01,8'h01,8'h05,
        8'h03,8'h0F,8'h0F,8'h0F,8'h2F,8'h2F,8'hAF,8'h6F},
      '{8'h1F,8'h03,8'h07,8'h07,8'h00,8'h01,8'h01,8'h05,
        8'h03,8'h0F,8'h0F,8'h0F,8'h2F,8'h2F,8'hAF,8'h6F},
      '{8'h0F,8'h01,8'h03,8'h03,8'h02,8'h00,8'h00,8'h02,
        8'h01,8'h07,8'h07,8'h07,8'h17,8'h17,8'h57,8'h37},
      '{8'h1F,8'h03,8'h07,8'h07,8'h01,8'h05,8'h00,8'h01,
        8'h03,8'h0F,8'h0F,8'h0F,8'h2F,8'h2F,8'hAF,8'h6F},
      '{8'h0F,8'h01,8'h03,8'h03,8'h00,8'h02,8'h02,8'h00,
        8'h01,8'h07,8'h07,8'h07,8'h17,8'h17,8'h57,8'h37},
      '{8'h07,8'h00,8'h01,8'h01,8'h01,8'h05,8'h05,8'h15,
        8'h00,8'h03,8'h03,8'h03,8'h0B,8'h0B,8'h2B,8'h1B},
      '{8'h01,8'h01,8'h05,8'h05,8'h05,8'h15,8'h15,8'h55,
        8'h35,8'h00,8'h00,8'h00,8'h02,8'h02,8'h0A,8'h06},
      '{8'h1F,8'h03,8'h07,8'h07,8'h07,8'h17,8'h17,8'h57,
        8'h37,8'h0F,8'h00,8'h00,8'h01,8'h01,8'h05,8'h03},
      '{8'h1F,8'h03,8'h07,8'h07,8'h07,8'h17,8'h17,8'h57,
        8'h37,8'h0F,8'h0F,8'h00,8'h01,8'h01,8'h05,8'h03},
      '{8'h0F,8'h01,8'h03,8'h03,8'h03,8'h0B,8'h0B,8'h2B,
        8'h1B,8'h07,8'h07,8'h02,8'h00,8'h00,8'h02,8'h01},
      '{8'h1F,8'h03,8'h07,8'h07,8'h07,8'h17,8'h17,8'h57,
        8'h37,8'h0F,8'h0F,8'h01,8'h05,8'h00,8'h01,8'h03},
      '{8'h0F,8'h01,8'h03,8'h03,8'h03,8'h0B,8'h0B,8'h2B,
        8'h1B,8'h07,8'h07,8'h00,8'h02,8'h02,8'h00,8'h01},
      '{8'h07,8'h00,8'h01,8'h01,8'h01,8'h05,8'h05,8'h15,
        8'h0D,8'h03,8'h03,8'h03,8'h0B,8'h0B,8'h2B,8'h00}
   };

   // Shortest-path tick counts, [from][to]
   localparam logic [3:0] PATH_LEN [16][16] = '{
      '{4'd0,4'd1,4'd2,4'd3,4'd4,4'd4,4'd5,4'd6,4'd5,4'd3,4'd4,4'd5,4'd5,4'd6,4'd7,4'd6},
      '{4'd3,4'd0,4'd1,4'd2,4'd3,4'd3,4'd4,4'd5,4'd4,4'd2,4'd3,4'd4,4'd4,4'd5,4'd6,4'd5},
      '{4'd2,4'd3,4'd0,4'd1,4'd2,4'd2,4'd3,4'd4,4'd3,4'd1,4'd2,4'd3,4'd3,4'd4,4'd5,4'd4},
      '{4'd5,4'd3,4'd3,4'd0,4'd1,4'd1,4'd2,4'd3,4'd2,4'd4,4'd5,4'd6,4'd6,4'd7,4'd8,4'd7},
      '{4'd5,4'd3,4'd3,4'd4,4'd0,4'd1,4'd2,4'd3,4'd2,4'd4,4'd5,4'd6,4'd6,4'd7,4'd8,4'd7},
      '{4'd4,4'd2,4'd2,4'd3,4'd3,4'd0,4'd1,4'd2,4'd1,4'd3,4'd4,4'd5,4'd5,4'd6,4'd7,4'd6},
      '{4'd5,4'd3,4'd3,4'd4,4'd2,4'd3,4'd0,4'd1,4'd2,4'd4,4'd5,4'd6,4'd6,4'd7,4'd8,4'd7},
      '{4'd4,4'd2,4'd2,4'd3,4'd1,4'd2,4'd3,4'd0,4'd1,4'd3,4'd4,4'd5,4'd5,4'd6,4'd7,4'd6},
      '{4'd3,4'd1,4'd1,4'd2,4'd3,4'd3,4'd4,4'd5,4'd0,4'd2,4'd3,4'd4,4'd4,4'd5,4'd6,4'd5},
      '{4'd1,4'd2,4'd3,4'd4,4'd5,4'd5,4'd6,4'd7,4'd6,4'd0,4'd1,4'd2,4'd2,4'd3,4'd4,4'd3},
      '{4'd5,4'd3,4'd3,4'd4,4'd5,4'd5,4'd6,4'd7,4'd6,4'd4,4'd0,4'd1,4'd1,4'd2,4'd3,4'd2},
      '{4'd5,4'd3,4'd3,4'd4,4'd5,4'd5,4'd6,4'd7,4'd6,4'd4,4'd5,4'd0,4'd1,4'd2,4'd3,4'd2},
      '{4'd4,4'd2,4'd2,4'd3,4'd4,4'd4,4'd5,4'd6,4'd5,4'd3,4'd4,4'd3,4'd0,4'd1,4'd2,4'd1},
      '{4'd5,4'd3,4'd3,4'd4,4'd5,4'd5,4'd6,4'd7,4'd6,4'd4,4'd5,4'd2,4'd3,4'd0,4'd1,4'd2},
      '{4'd4,4'd2,4'd2,4'd3,4'd4,4'd4,4'd5,4'd6,4'd5,4'd3,4'd4,4'd1,4'd2,4'd3,4'd0,4'd1},
      '{4'd3,4'd1,4'd1,4'd2,4'd3,4'd3,4'd4,4'd5,4'd4,4'd2,4'd3,4'd4,4'd4,4'd5,4'd6,4'd0}
   };

   // Microcode entry point for a command; unknown codes finish at once
   function automatic logic [UPC_W-1:0] entry_upc(input logic [OP_W-1:0] op);
      logic [UPC_W-1:0] upc;
      priority case (op)
         OP_RESET:    upc = UPC_RESET;
         OP_GOTO:     upc = UPC_GOTO;
         OP_RUN:      upc = UPC_RUN;
         OP_SHIFT_IR: upc = UPC_SHIFT_IR;
         OP_WRITE_DR: upc = UPC_SHIFT_DR;
         OP_READ_DR:  upc = UPC_SHIFT_DR;
         default:     upc = UPC_DONE;
      endcase
      return upc;
   endfunction

endpackage

// ===== hw/rtl/jtms_if.sv =====
// Valid/ready channel interfaces for the JTAG master TAP sequencer.
// Depends on jtms_pkg for field widths.
interface jtms_req_if;
   logic                          valid;
   logic                          ready;
   logic [jtms_pkg::OP_W-1:0]     op;
   logic [jtms_pkg::TAP_W-1:0]    goal_state;
   logic [jtms_pkg::CNT_W-1:0]    clock_count;
   logic [jtms_pkg::DATA_W-1:0]   shift_data;
   logic [jtms_pkg::CNT_W-1:0]    bit_count;
   logic [jtms_pkg::DATA_W-1:0]   target_tdo;

   modport source (output valid, op, goal_state, clock_count, shift_data, bit_count,
                   target_tdo, input ready);
   modport sink (input valid, op, goal_state, clock_count, shift_data, bit_count,
                 target_tdo, output ready);
endinterface

interface jtms_rsp_if;
   logic                          valid;
   logic                          ready;
   logic                          tick_valid;
   logic                          tms_level;
   logic                          tdi_level;
   logic                          last;
   logic [jtms_pkg::DATA_W-1:0]   captured_bits;
   logic [jtms_pkg::TAP_W-1:0]    tap_now;

   modport source (output valid, tick_valid, tms_level, tdi_level, last, captured_bits,
                   tap_now, input ready);
   modport sink (input valid, tick_valid, tms_level, tdi_level, last, captured_bits,
                 tap_now, output ready);
endinterface

// ===== hw/rtl/jtms_urom.sv =====
// Microcode ROM: one control word per step of each command program.
// Depends on jtms_pkg for the control word type.
module jtms_urom (
   input  logic [jtms_pkg::UPC_W-1:0] upc,
   output jtms_pkg::uword_type        uword
);

   // Programs: reset, goto, run clocks, shift IR, shift DR; each ends in a done step
   always_comb begin
      unique case (upc)
         4'd0:  uword = '{jtms_pkg::UOP_CLOCK, jtms_pkg::DST_TARGET, jtms_pkg::CNT_RESET, 1'b1};
         4'd1:  uword = '{jtms_pkg::UOP_DONE,  jtms_pkg::DST_TARGET, jtms_pkg::CNT_RESET, 1'b0};
         4'd2:  uword = '{jtms_pkg::UOP_WALK,  jtms_pkg::DST_TARGET, jtms_pkg::CNT_RESET, 1'b0};
         4'd3:  uword = '{jtms_pkg::UOP_DONE,  jtms_pkg::DST_TARGET, jtms_pkg::CNT_RESET, 1'b0};
         4'd4:  uword = '{jtms_pkg::UOP_WALK,  jtms_pkg::DST_RTI,    jtms_pkg::CNT_RESET, 1'b0};
         4'd5:  uword = '{jtms_pkg::UOP_CLOCK, jtms_pkg::DST_TARGET, jtms_pkg::CNT_IDLE,  1'b0};
         4'd6:  uword = '{jtms_pkg::UOP_WALK,  jtms_pkg::DST_TARGET, jtms_pkg::CNT_RESET, 1'b0};
         4'd7:  uword = '{jtms_pkg::UOP_DONE,  jtms_pkg::DST_TARGET, jtms_pkg::CNT_RESET, 1'b0};
         4'd8:  uword = '{jtms_pkg::UOP_WALK,  jtms_pkg::DST_SIR,    jtms_pkg::CNT_RESET, 1'b0};
         4'd9:  uword = '{jtms_pkg::UOP_SHIFT, jtms_pkg::DST_TARGET, jtms_pkg::CNT_IR,    1'b0};
         4'd10: uword = '{jtms_pkg::UOP_WALK,  jtms_pkg::DST_TARGET, jtms_pkg::CNT_RESET, 1'b0};
         4'd11: uword = '{jtms_pkg::UOP_DONE,  jtms_pkg::DST_TARGET, jtms_pkg::CNT_RESET, 1'b0};
         4'd12: uword = '{jtms_pkg::UOP_WALK,  jtms_pkg::DST_SDR,    jtms_pkg::CNT_RESET, 1'b0};
         4'd13: uword = '{jtms_pkg::UOP_SHIFT, jtms_pkg::DST_TARGET, jtms_pkg::CNT_BITS,  1'b0};
         4'd14: uword = '{jtms_pkg::UOP_WALK,  jtms_pkg::DST_TARGET, jtms_pkg::CNT_RESET, 1'b0};
         4'd15: uword = '{jtms_pkg::UOP_DONE,  jtms_pkg::DST_TARGET, jtms_pkg::CNT_RESET, 1'b0};
         default: uword = '{jtms_pkg::UOP_DONE, jtms_pkg::DST_TARGET, jtms_pkg::CNT_RESET, 1'b0};
      endcase
   end

endmodule

// ===== hw/rtl/jtms_seq.sv =====
// Microcode sequencer: step counter, per-step tick counter and TMS path register.
// Depends on jtms_pkg; reads control words from jtms_urom.
module jtms_seq (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  jtms_pkg::cmd_type             cmd,
   input  jtms_pkg::uword_type           uword,
   input  jtms_pkg::dp_status_type       status,
   output logic [jtms_pkg::UPC_W-1:0]    upc,
   output logic                          idle,
   output jtms_pkg::ctrl_type            ctrl
);

   jtms_pkg::seq_state_type             state_ff, state_in;
   logic [jtms_pkg::UPC_W-1:0]          upc_ff, upc_in;
   logic [jtms_pkg::CNT_W-1:0]          cnt_ff, cnt_in;
   logic [jtms_pkg::PATH_W-1:0]         pbits_ff, pbits_in;
   jtms_pkg::uop_kind_type              kind_ff, kind_in;
   logic                                tms_ff, tms_in;
   logic [jtms_pkg::TAP_W-1:0]          dest;
   logic [jtms_pkg::CNT_W-1:0]          step_count;
   logic [jtms_pkg::TAP_W-1:0]          shift_home;
   logic                                leave;
   logic                                reading;

   // Select the walk destination of this step
   always_comb begin
      unique case (uword.dst)
         jtms_pkg::DST_TARGET: dest = cmd.target;
         jtms_pkg::DST_RTI:    dest = jtms_pkg::TAP_RTI;
         jtms_pkg::DST_SIR:    dest = jtms_pkg::TAP_SIR;
         jtms_pkg::DST_SDR:    dest = jtms_pkg::TAP_SDR;
         default:              dest = cmd.target;
      endcase
   end

   // Select the tick count of a clock or shift step
   always_comb begin
      unique case (uword.cnt)
         jtms_pkg::CNT_RESET: step_count = jtms_pkg::CNT_W'(jtms_pkg::RESET_TICKS);
         jtms_pkg::CNT_IDLE:  step_count = cmd.idle;
         jtms_pkg::CNT_IR:    step_count = jtms_pkg::CNT_W'(jtms_pkg::IR_LENGTH);
         jtms_pkg::CNT_BITS:  step_count = cmd.nbits;
         default:             step_count = cmd.nbits;
      endcase
   end

   // Leave the shift state on the last bit unless the command ends there
   assign shift_home = (cmd.op == jtms_pkg::OP_SHIFT_IR) ? jtms_pkg::TAP_SIR
                                                         : jtms_pkg::TAP_SDR;
   assign leave      = (cmd.target != shift_home);
   assign reading    = (cmd.op == jtms_pkg::OP_READ_DR);

   // Next state and control outputs
   always_comb begin
      state_in = state_ff;
      upc_in   = upc_ff;
      cnt_in   = cnt_ff;
      pbits_in = pbits_ff;
      kind_in  = kind_ff;
      tms_in   = tms_ff;
      ctrl     = '0;
      unique case (state_ff)
         jtms_pkg::SEQ_IDLE: begin
            if (start) begin
               upc_in   = jtms_pkg::entry_upc(cmd.op);
               state_in = jtms_pkg::SEQ_LOAD;
            end
         end
         jtms_pkg::SEQ_LOAD: begin
            kind_in = uword.kind;
            tms_in  = uword.tms;
            unique case (uword.kind)
               jtms_pkg::UOP_WALK: begin
                  cnt_in   = jtms_pkg::CNT_W'(jtms_pkg::PATH_LEN[status.tap][dest]);
                  pbits_in = jtms_pkg::PATH_BITS[status.tap][dest];
                  state_in = jtms_pkg::SEQ_STEP;
               end
               jtms_pkg::UOP_CLOCK, jtms_pkg::UOP_SHIFT: begin
                  cnt_in   = step_count;
                  state_in = jtms_pkg::SEQ_STEP;
               end
               jtms_pkg::UOP_DONE: begin
                  state_in = jtms_pkg::SEQ_FINISH;
               end
               default: begin
                  state_in = jtms_pkg::SEQ_FINISH;
               end
            endcase
         end
         jtms_pkg::SEQ_STEP: begin
            // Jump to the next step once the count runs out, else tick when there is room
            if (cnt_ff == '0) begin
               upc_in   = upc_ff + jtms_pkg::UPC_W'(1);
               state_in = jtms_pkg::SEQ_LOAD;
            end else if (status.room_tick) begin
               ctrl.tick = 1'b1;
               cnt_in    = cnt_ff - jtms_pkg::CNT_W'(1);
               pbits_in  = pbits_ff >> 1;
               unique case (kind_ff)
                  jtms_pkg::UOP_WALK:  ctrl.tms = pbits_ff[0];
                  jtms_pkg::UOP_CLOCK: ctrl.tms = tms_ff;
                  jtms_pkg::UOP_SHIFT: begin
                     ctrl.tms      = (cnt_ff == jtms_pkg::CNT_W'(1)) && leave;
                     ctrl.use_data = !reading;
                  end
                  default: ctrl.tms = 1'b0;
               endcase
            end
         end
         jtms_pkg::SEQ_FINISH: begin
            if (status.room_out) begin
               ctrl.finish = 1'b1;
               state_in    = jtms_pkg::SEQ_IDLE;
            end
         end
         default: state_in = jtms_pkg::SEQ_IDLE;
      endcase
   end

   // Sequencer registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= jtms_pkg::SEQ_IDLE;
         upc_ff   <= '0;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         upc_ff   <= upc_in;
         cnt_ff   <= cnt_in;
      end
      pbits_ff <= pbits_in;
      kind_ff  <= kind_in;
      tms_ff   <= tms_in;
   end

   assign upc  = upc_ff;
   assign idle = (state_ff == jtms_pkg::SEQ_IDLE);

endmodule

// ===== hw/rtl/jtms_dp.sv =====
// Datapath: TAP position, shift data, capture, pending tick and output register.
// Depends on jtms_pkg and the assertion macro header.
`include "jtag_master_tap_sequencer_unit_macros.svh"
module jtms_dp (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            load,
   input  logic [jtms_pkg::OP_W-1:0]       load_op,
   input  logic [jtms_pkg::CNT_W-1:0]      load_nbits,
   input  logic [jtms_pkg::DATA_W-1:0]     load_data,
   input  logic [jtms_pkg::DATA_W-1:0]     load_tdo,
   input  jtms_pkg::ctrl_type              ctrl,
   output jtms_pkg::dp_status_type         status,
   input  logic                            rsp_ready,
   output logic                            rsp_valid,
   output jtms_pkg::rsp_payload_type       rsp_payload
);

   logic [jtms_pkg::TAP_W-1:0]    tap_ff, tap_in;
   logic [jtms_pkg::DATA_W-1:0]   data_ff, data_in;
   logic [jtms_pkg::DATA_W-1:0]   cap_ff, cap_in;
   logic                          pend_valid_ff, pend_valid_in;
   logic                          pend_tms_ff, pend_tms_in;
   logic                          pend_tdi_ff, pend_tdi_in;
   logic [jtms_pkg::TAP_W-1:0]    pend_tap_ff, pend_tap_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   jtms_pkg::rsp_payload_type     rsp_ff, rsp_in;
   logic                          out_free;
   logic                          tick_tdi;
   logic [jtms_pkg::DATA_W:0]     bit_lim;
   logic [jtms_pkg::DATA_W-1:0]   cap_mask;

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign tick_tdi = ctrl.use_data ? data_ff[0] : 1'b1;

   // Keep the TDO bits of the ticks that a read shifts
   assign bit_lim  = (jtms_pkg::DATA_W + 1)'(1) << load_nbits;
   assign cap_mask = bit_lim[jtms_pkg::DATA_W-1:0] - jtms_pkg::DATA_W'(1);

   always_comb begin
      tap_in        = tap_ff;
      data_in       = data_ff;
      cap_in        = cap_ff;
      pend_valid_in = pend_valid_ff;
      pend_tms_in   = pend_tms_ff;
      pend_tdi_in   = pend_tdi_ff;
      pend_tap_in   = pend_tap_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_in        = rsp_ff;

      // Latch the command data
      if (load) begin
         data_in = load_data;
         cap_in  = (load_op == jtms_pkg::OP_READ_DR) ? (load_tdo & cap_mask) : '0;
      end

      // Advance the TAP; hold the new tick until the next one shows it is not last
      if (ctrl.tick) begin
         tap_in        = jtms_pkg::TAP_NEXT[tap_ff][ctrl.tms];
         pend_valid_in = 1'b1;
         pend_tms_in   = ctrl.tms;
         pend_tdi_in   = tick_tdi;
         pend_tap_in   = jtms_pkg::TAP_NEXT[tap_ff][ctrl.tms];
         if (ctrl.use_data) begin
            data_in = data_ff >> 1;
         end
         if (pend_valid_ff) begin
            rsp_valid_in         = 1'b1;
            rsp_in.tick_valid    = 1'b1;
            rsp_in.tms_level     = pend_tms_ff;
            rsp_in.tdi_level     = pend_tdi_ff;
            rsp_in.last          = 1'b0;
            rsp_in.captured_bits = '0;
            rsp_in.tap_now       = pend_tap_ff;
         end
      end

      // Close the command: mark the held tick last, or send the empty result
      if (ctrl.finish) begin
         pend_valid_in        = 1'b0;
         rsp_valid_in         = 1'b1;
         rsp_in.last          = 1'b1;
         if (pend_valid_ff) begin
            rsp_in.tick_valid    = 1'b1;
            rsp_in.tms_level     = pend_tms_ff;
            rsp_in.tdi_level     = pend_tdi_ff;
            rsp_in.captured_bits = cap_ff;
            rsp_in.tap_now       = pend_tap_ff;
         end else begin
            rsp_in.tick_valid    = 1'b0;
            rsp_in.tms_level     = 1'b0;
            rsp_in.tdi_level     = 1'b0;
            rsp_in.captured_bits = '0;
            rsp_in.tap_now       = tap_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tap_ff        <= jtms_pkg::TAP_TLR;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         tap_ff        <= tap_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      data_ff     <= data_in;
      cap_ff      <= cap_in;
      pend_tms_ff <= pend_tms_in;
      pend_tdi_ff <= pend_tdi_in;
      pend_tap_ff <= pend_tap_in;
      rsp_ff      <= rsp_in;
   end

   assign status.room_tick = !pend_valid_ff || out_free;
   assign status.room_out  = out_free;
   assign status.tap       = tap_ff;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_payload      = rsp_ff;

   `JTMS_ASSERT_NOW(a_push_has_room, ctrl.tick && pend_valid_ff, out_free)
   `JTMS_ASSERT_NOW(a_finish_has_room, ctrl.finish, out_free)
   `JTMS_ASSERT_NEXT(a_finish_marks_last, ctrl.finish, rsp_valid_ff && rsp_ff.last && !pend_valid_ff)
   `JTMS_ASSERT_NEXT(a_tap_follows_tms, ctrl.tick, tap_ff == jtms_pkg::TAP_NEXT[$past(tap_ff)][$past(ctrl.tms)])

endmodule

// ===== hw/rtl/jtag_master_tap_sequencer_unit.sv =====
// Top level of the JTAG master TAP sequencer: command register and channel glue.
// Depends on jtms_pkg, jtms_if, jtms_urom, jtms_seq and jtms_dp.
//
//   channel   dir  handshake     carries
//   req_chan  in   valid/ready   one command (op, target, counts, data, TDO)
//   rsp_chan  out  valid/ready   one TCK tick per result, or one empty result
//
// From one accepted request to the next: a start, then for each microcode step a load
// and either its TCK ticks up to the end of count or the close, then the sequencer
// is idle again with ready high.
// Programs have one step (unknown op), two (reset, goto) or four (run, shifts);
// at most 57 ticks on a run command.
// Reset returns the TAP position to test logic reset; no clearing pass.
// A stalled result holds the sequencer when a held tick must move out or the
// command closes.
module jtag_master_tap_sequencer_unit (
   input  logic           clock,
   input  logic           reset,
   jtms_req_if.sink       req_chan,
   jtms_rsp_if.source     rsp_chan
);

   logic                          accept;
   logic                          start_ff;
   jtms_pkg::cmd_type             cmd_ff, cmd_in;
   jtms_pkg::uword_type           uword;
   logic [jtms_pkg::UPC_W-1:0]    upc;
   logic                          seq_idle;
   jtms_pkg::ctrl_type            ctrl;
   jtms_pkg::dp_status_type       status;
   jtms_pkg::rsp_payload_type     rsp_payload;
   logic                          rsp_valid;

   assign req_chan.ready = seq_idle && !start_ff && !reset;
   assign accept         = req_chan.valid && req_chan.ready;

   // Saturate the counts as the request comes in
   always_comb begin
      cmd_in.op     = req_chan.op;
      cmd_in.target = req_chan.goal_state;
      cmd_in.idle   = (req_chan.clock_count > jtms_pkg::CNT_W'(jtms_pkg::MAX_IDLE))
                      ? jtms_pkg::CNT_W'(jtms_pkg::MAX_IDLE) : req_chan.clock_count;
      cmd_in.nbits  = (req_chan.bit_count > jtms_pkg::CNT_W'(jtms_pkg::MAX_SHIFT_BITS))
                      ? jtms_pkg::CNT_W'(jtms_pkg::MAX_SHIFT_BITS) : req_chan.bit_count;
   end

   // Hold the command for the whole program
   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff <= 1'b0;
      end else begin
         start_ff <= accept;
      end
      if (accept) begin
         cmd_ff <= cmd_in;
      end
   end

   jtms_urom u_urom (
      .upc   (upc),
      .uword (uword)
   );

   jtms_seq u_seq (
      .clock  (clock),
      .reset  (reset),
      .start  (start_ff),
      .cmd    (cmd_ff),
      .uword  (uword),
      .status (status),
      .upc    (upc),
      .idle   (seq_idle),
      .ctrl   (ctrl)
   );

   jtms_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .load        (accept),
      .load_op     (req_chan.op),
      .load_nbits  (cmd_in.nbits),
      .load_data   (req_chan.shift_data),
      .load_tdo    (req_chan.target_tdo),
      .ctrl        (ctrl),
      .status      (status),
      .rsp_ready   (rsp_chan.ready),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload)
   );

   assign rsp_chan.valid         = rsp_valid;
   assign rsp_chan.tick_valid    = rsp_payload.tick_valid;
   assign rsp_chan.tms_level     = rsp_payload.tms_level;
   assign rsp_chan.tdi_level     = rsp_payload.tdi_level;
   assign rsp_chan.last          = rsp_payload.last;
   assign rsp_chan.captured_bits = rsp_payload.captured_bits;
   assign rsp_chan.tap_now       = rsp_payload.tap_now;

endmodule

// ===== bench/jtag_master_tap_sequencer_unit_tb.sv =====
// Self-checking bench for the JTAG master TAP sequencer: a directed table, then random commands.
// Each result is compared with a TAP walk predicted inside the bench, or with a fixed directed row.
// Depends on jtms_pkg, jtms_if and the jtag_master_tap_sequencer_unit RTL.
module jtag_master_tap_sequencer_unit_tb;

   localparam int RANDOM_ITEMS = 360;
   localparam int DRAIN_CYCLES = 80;
   localparam logic [jtms_pkg::OP_W-1:0] OP_UNUSED_6 = 3'd6;
   localparam logic [jtms_pkg::OP_W-1:0] OP_UNUSED_7 = 3'd7;

   typedef enum logic [jtms_pkg::TAP_W-1:0] {
      ST_TLR, ST_RTI, ST_SDS, ST_CDR, ST_SDR, ST_E1D, ST_PDR, ST_E2D,
      ST_UDR, ST_SIS, ST_CIR, ST_SIR, ST_E1I, ST_PIR, ST_E2I, ST_UIR
   } tap_state_type;

   typedef struct packed {
      logic [jtms_pkg::OP_W-1:0]   op;
      logic [jtms_pkg::TAP_W-1:0]  target;
      logic [jtms_pkg::CNT_W-1:0]  clocks;
      logic [jtms_pkg::DATA_W-1:0] data;
      logic [jtms_pkg::CNT_W-1:0]  nbits;
      logic [jtms_pkg::DATA_W-1:0] tdo;
   } jtag_cmd_type;

   typedef struct {
      jtag_cmd_type              cmd;
      bit                        typed;
      jtms_pkg::rsp_payload_type want;
   } directed_row_type;

   // TAP successor for TMS=0 and TMS=1
   localparam logic [3:0] TAP_SUCC [16][2] = '{
      '{4'd1, 4'd0},   '{4'd1, 4'd2},   '{4'd3, 4'd9},   '{4'd4, 4'd5},
      '{4'd4, 4'd5},   '{4'd6, 4'd8},   '{4'd6, 4'd7},   '{4'd4, 4'd8},
      '{4'd1, 4'd2},   '{4'd10, 4'd0},  '{4'd11, 4'd12}, '{4'd11, 4'd12},
      '{4'd13, 4'd15}, '{4'd13, 4'd14}, '{4'd11, 4'd15}, '{4'd1, 4'd2}
   };

   // Shortest route TMS bits, LSB first, [from][to]
   localparam logic [7:0] ROUTE_TMS [16][16] = '{
      '{'h00,'h00,'h02,'h02,'h02,'h0A,'h0A,'h2A,'h1A,'h06,'h06,'h06,'h16,'h16,'h56,'h36},
      '{'h07,'h00,'h01,'h01,'h01,'h05,'h05,'h15,'h0D,'h03,'h03,'h03,'h0B,'h0B,'h2B,'h1B},
      '{'h03,'h03,'h00,'h00,'h00,'h02,'h02,'h0A,'h06,'h01,'h01,'h01,'h05,'h05,'h15,'h0D},
      '{'h1F,'h03,'h07,'h00,'h00,'h01,'h01,'h05,'h03,'h0F,'h0F,'h0F,'h2F,'h2F,'hAF,'h6F},
      '{'h1F,'h03,'h07,'h07,'h00,'h01,'h01,'h05,'h03,'h0F,'h0F,'h0F,'h2F,'h2F,'hAF,'h6F},
      '{'h0F,'h01,'h03,'h03,'h02,'h00,'h00,'h02,'h01,'h07,'h07,'h07,'h17,'h17,'h57,'h37},
      '{'h1F,'h03,'h07,'h07,'h01,'h05,'h00,'h01,'h03,'h0F,'h0F,'h0F,'h2F,'h2F,'hAF,'h6F},
      '{'h0F,'h01,'h03,'h03,'h00,'h02,'h02,'h00,'h01,'h07,'h07,'h07,'h17,'h17,'h57,'h37},
      '{'h07,'h00,'h01,'h01,'h01,'h05,'h05,'h15,'h00,'h03,'h03,'h03,'h0B,'h0B,'h2B,'h1B},
      '{'h01,'h01,'h05,'h05,'h05,'h15,'h15,'h55,'h35,'h00,'h00,'h00,'h02,'h02,'h0A,'h06},
      '{'h1F,'h03,'h07,'h07,'h07,'h17,'h17,'h57,'h37,'h0F,'h00,'h00,'h01,'h01,'h05,'h03},
      '{'h1F,'h03,'h07,'h07,'h07,'h17,'h17,'h57,'h37,'h0F,'h0F,'h00,'h01,'h01,'h05,'h03},
      '{'h0F,'h01,'h03,'h03,'h03,'h0B,'h0B,'h2B,'h1B,'h07,'h07,'h02,'h00,'h00,'h02,'h01},
      '{'h1F,'h03,'h07,'h07,'h07,'h17,'h17,'h57,'h37,'h0F,'h0F,'h01,'h05,'h00,'h01,'h03},
      '{'h0F,'h01,'h03,'h03,'h03,'h0B,'h0B,'h2B,'h1B,'h07,'h07,'h00,'h02,'h02,'h00,'h01},
      '{'h07,'h00,'h01,'h01,'h01,'h05,'h05,'h15,'h0D,'h03,'h03,'h03,'h0B,'h0B,'h2B,'h00}
   };

   // Shortest route tick counts, [from][to]
   localparam int ROUTE_LEN [16][16] = '{
      '{0,1,2,3,4,4,5,6,5,3,4,5,5,6,7,6},
      '{3,0,1,2,3,3,4,5,4,2,3,4,4,5,6,5},
      '{2,3,0,1,2,2,3,4,3,1,2,3,3,4,5,4},
      '{5,3,3,0,1,1,2,3,2,4,5,6,6,7,8,7},
      '{5,3,3,4,0,1,2,3,2,4,5,6,6,7,8,7},
      '{4,2,2,3,3,0,1,2,1,3,4,5,5,6,7,6},
      '{5,3,3,4,2,3,0,1,2,4,5,6,6,7,8,7},
      '{4,2,2,3,1,2,3,0,1,3,4,5,5,6,7,6},
      '{3,1,1,2,3,3,4,5,0,2,3,4,4,5,6,5},
      '{1,2,3,4,5,5,6,7,6,0,1,2,2,3,4,3},
      '{5,3,3,4,5,5,6,7,6,4,0,1,1,2,3,2},
      '{5,3,3,4,5,5,6,7,6,4,5,0,1,2,3,2},
      '{4,2,2,3,4,4,5,6,5,3,4,3,0,1,2,1},
      '{5,3,3,4,5,5,6,7,6,4,5,2,3,0,1,2},
      '{4,2,2,3,4,4,5,6,5,3,4,1,2,3,0,1},
      '{3,1,1,2,3,3,4,5,4,2,3,4,4,5,6,0}
   };

   logic clock;
   logic reset;
   bit   calm;
   int   mismatch_count;

   logic [jtms_pkg::TAP_W-1:0] tap_model;
   jtms_pkg::rsp_payload_type  tick_plan[$];
   jtms_pkg::rsp_payload_type  tick_expect_q[$];
   directed_row_type           directed_rows[$];

   jtms_req_if req_chan();
   jtms_rsp_if rsp_chan();

   jtag_master_tap_sequencer_unit i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Hard stop in case the block hangs
   initial begin
      #40_000_000;
      $display("DONE: errors detected");
      $finish;
   end

   // Append one predicted TCK tick and advance the TAP copy
   function automatic void plan_tick(input logic tms, input logic tdi);
      jtms_pkg::rsp_payload_type t;
      tap_model = TAP_SUCC[tap_model][tms];
      t = '{tick_valid: 1'b1, tms_level: tms, tdi_level: tdi, last: 1'b0,
            captured_bits: '0, tap_now: tap_model};
      tick_plan.push_back(t);
   endfunction

   // Walk the shortest route with TDI high
   function automatic void plan_route(input logic [jtms_pkg::TAP_W-1:0] dest);
      logic [7:0] bits;
      int         len;
      bits = ROUTE_TMS[tap_model][dest];
      len  = ROUTE_LEN[tap_model][dest];
      for (int i = 0; i < len; i++) plan_tick(bits[i], 1'b1);
   endfunction

   // Shift data LSB first; leave the shift state on the last bit if asked
   function automatic logic [jtms_pkg::DATA_W-1:0] plan_shift(
      input int len, input logic [jtms_pkg::DATA_W-1:0] data, input bit reading,
      input logic [jtms_pkg::DATA_W-1:0] tdo, input bit leave);
      logic [jtms_pkg::DATA_W-1:0] got;
      got = '0;
      for (int i = 0; i < len; i++) begin
         plan_tick((i == len - 1) && leave, reading ? 1'b1 : data[i]);
         got[i] = tdo[i];
      end
      return got;
   endfunction

   // Predict every result a command causes into tick_plan
   function automatic void predict_command(input jtag_cmd_type c);
      int                          idle;
      int                          nbits;
      logic [jtms_pkg::DATA_W-1:0] cap;
      idle  = (c.clocks > jtms_pkg::MAX_IDLE) ? jtms_pkg::MAX_IDLE : c.clocks;
      nbits = (c.nbits > jtms_pkg::MAX_SHIFT_BITS) ? jtms_pkg::MAX_SHIFT_BITS : c.nbits;
      cap   = '0;
      tick_plan.delete();
      case (c.op)
         jtms_pkg::OP_RESET: begin
            for (int i = 0; i < jtms_pkg::RESET_TICKS; i++) plan_tick(1'b1, 1'b1);
         end
         jtms_pkg::OP_GOTO: begin
            plan_route(c.target);
         end
         jtms_pkg::OP_RUN: begin
            plan_route(ST_RTI);
            for (int i = 0; i < idle; i++) plan_tick(1'b0, 1'b1);
            plan_route(c.target);
         end
         jtms_pkg::OP_SHIFT_IR: begin
            plan_route(ST_SIR);
            void'(plan_shift(jtms_pkg::IR_LENGTH, c.data, 1'b0, '0, c.target != ST_SIR));
            plan_route(c.target);
         end
         jtms_pkg::OP_WRITE_DR, jtms_pkg::OP_READ_DR: begin
            plan_route(ST_SDR);
            cap = plan_shift(nbits, c.data, c.op == jtms_pkg::OP_READ_DR, c.tdo,
                             c.target != ST_SDR);
            plan_route(c.target);
            if (c.op != jtms_pkg::OP_READ_DR) cap = '0;
         end
         default: ;
      endcase
      // Empty command: one result that carries only the position
      if (tick_plan.size() == 0) begin
         tick_plan.push_back('{tick_valid: 1'b0, tms_level: 1'b0, tdi_level: 1'b0, last: 1'b0,
                               captured_bits: '0, tap_now: tap_model});
      end
      tick_plan[$].last          = 1'b1;
      tick_plan[$].captured_bits = cap;
   endfunction

   function automatic void add_row(input logic [jtms_pkg::OP_W-1:0] op,
                                   input tap_state_type target, input int clocks,
                                   input logic [jtms_pkg::DATA_W-1:0] data, input int nbits,
                                   input logic [jtms_pkg::DATA_W-1:0] tdo,
                                   input bit typed = 1'b0,
                                   input jtms_pkg::rsp_payload_type want = '0);
      directed_row_type row;
      row.cmd   = '{op: op, target: target, clocks: clocks[jtms_pkg::CNT_W-1:0], data: data,
                    nbits: nbits[jtms_pkg::CNT_W-1:0], tdo: tdo};
      row.typed = typed;
      row.want  = want;
      directed_rows.push_back(row);
   endfunction

   // Mostly short gaps, now and then a long one
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 40);
   endfunction

   function automatic jtag_cmd_type random_cmd();
      jtag_cmd_type c;
      int           r;
      r = $urandom_range(0, 99);
      if (r < 3)       c.op = $urandom_range(0, 1) ? OP_UNUSED_6 : OP_UNUSED_7;
      else if (r < 12) c.op = jtms_pkg::OP_RESET;
      else if (r < 28) c.op = jtms_pkg::OP_GOTO;
      else if (r < 45) c.op = jtms_pkg::OP_RUN;
      else if (r < 62) c.op = jtms_pkg::OP_SHIFT_IR;
      else if (r < 81) c.op = jtms_pkg::OP_WRITE_DR;
      else             c.op = jtms_pkg::OP_READ_DR;
      // Bias the end state toward the shift and idle states
      r = $urandom_range(0, 99);
      if (r < 10)      c.target = ST_SDR;
      else if (r < 20) c.target = ST_SIR;
      else if (r < 28) c.target = ST_RTI;
      else             c.target = jtms_pkg::TAP_W'($urandom_range(0, 15));
      c.clocks = jtms_pkg::CNT_W'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 63)
                                                               : $urandom_range(0, 8));
      c.nbits  = jtms_pkg::CNT_W'(($urandom_range(0, 6) == 0) ? $urandom_range(0, 63)
                                                               : $urandom_range(0, 32));
      c.data   = $urandom;
      c.tdo    = $urandom;
      return c;
   endfunction

   // Compare one accepted result with the oldest expectation
   task automatic check_tick(input jtms_pkg::rsp_payload_type want);
      if (rsp_chan.tick_valid !== want.tick_valid) begin
         $error("tick_valid expected %0d got %0d", want.tick_valid, rsp_chan.tick_valid);
         mismatch_count++;
      end
      if (rsp_chan.tms_level !== want.tms_level) begin
         $error("tms_level expected %0d got %0d", want.tms_level, rsp_chan.tms_level);
         mismatch_count++;
      end
      if (rsp_chan.tdi_level !== want.tdi_level) begin
         $error("tdi_level expected %0d got %0d", want.tdi_level, rsp_chan.tdi_level);
         mismatch_count++;
      end
      if (rsp_chan.last !== want.last) begin
         $error("last expected %0d got %0d", want.last, rsp_chan.last);
         mismatch_count++;
      end
      if (rsp_chan.captured_bits !== want.captured_bits) begin
         $error("captured_bits expected %h got %h", want.captured_bits, rsp_chan.captured_bits);
         mismatch_count++;
      end
      if (rsp_chan.tap_now !== want.tap_now) begin
         $error("tap_now expected %0d got %0d", want.tap_now, rsp_chan.tap_now);
         mismatch_count++;
      end
   endtask

   // Result side: check accepted ticks, stall at random outside calm stretches
   initial begin : rsp_drain
      int stall_left;
      stall_left = 0;
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_chan.valid && rsp_chan.ready) begin
            if (tick_expect_q.size() == 0) begin
               $error("unexpected result tap_now %0d last %0d", rsp_chan.tap_now, rsp_chan.last);
               mismatch_count++;
            end else begin
               check_tick(tick_expect_q.pop_front());
            end
         end
         if (stall_left == 0 && !calm) stall_left = pick_gap();
         if (stall_left > 0) begin
            rsp_chan.ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   // Request side: reset, directed table, random commands, drain
   initial begin : req_feed
      jtag_cmd_type              cmd;
      int                        n_dir;
      int                        gap;
      jtms_pkg::rsp_payload_type empty_tlr, empty_rti, rti_tick;

      mismatch_count = 0;
      tap_model      = ST_TLR;
      calm           = 1'b0;
      reset                 <= 1'b1;
      req_chan.valid        <= 1'b0;
      req_chan.op           <= '0;
      req_chan.goal_state   <= '0;
      req_chan.clock_count  <= '0;
      req_chan.shift_data   <= '0;
      req_chan.bit_count    <= '0;
      req_chan.target_tdo   <= '0;

      empty_tlr = '{tick_valid: 1'b0, tms_level: 1'b0, tdi_level: 1'b0, last: 1'b1,
                    captured_bits: '0, tap_now: ST_TLR};
      empty_rti = empty_tlr;
      empty_rti.tap_now = ST_RTI;
      rti_tick  = '{tick_valid: 1'b1, tms_level: 1'b0, tdi_level: 1'b1, last: 1'b1,
                    captured_bits: '0, tap_now: ST_RTI};

      // Empty commands right after reset, then one-tick and zero-tick moves
      add_row(OP_UNUSED_7, ST_UIR, 63, '1, 63, '1, 1'b1, empty_tlr);
      add_row(OP_UNUSED_6, ST_TLR, 0, '0, 0, '0, 1'b1, empty_tlr);
      add_row(jtms_pkg::OP_GOTO, ST_TLR, 0, '0, 0, '0, 1'b1, empty_tlr);
      add_row(jtms_pkg::OP_GOTO, ST_RTI, 0, '0, 0, '0, 1'b1, rti_tick);
      add_row(jtms_pkg::OP_GOTO, ST_RTI, 0, '0, 0, '0, 1'b1, empty_rti);
      // Remaining rows go through the predictor
      add_row(jtms_pkg::OP_RESET, ST_E2I, 0, '0, 0, '0);
      add_row(jtms_pkg::OP_RUN, ST_RTI, 0, '0, 0, '0);
      add_row(jtms_pkg::OP_RUN, ST_TLR, 48, '0, 0, '0);
      add_row(jtms_pkg::OP_RUN, ST_UIR, 63, '1, 0, '0);
      add_row(jtms_pkg::OP_SHIFT_IR, ST_SIR, 0, '1, 0, '0);
      add_row(jtms_pkg::OP_SHIFT_IR, ST_SIR, 0, 32'h0000_002A, 0, '0);
      add_row(jtms_pkg::OP_SHIFT_IR, ST_RTI, 0, '0, 0, '0);
      add_row(jtms_pkg::OP_SHIFT_IR, ST_UIR, 0, 32'h0000_002A, 0, '0);
      add_row(jtms_pkg::OP_WRITE_DR, ST_RTI, 0, '1, 0, '1);
      add_row(jtms_pkg::OP_WRITE_DR, ST_SDR, 0, '1, 32, '0);
      add_row(jtms_pkg::OP_WRITE_DR, ST_PDR, 0, 32'h5555_5555, 63, '1);
      add_row(jtms_pkg::OP_READ_DR, ST_RTI, 0, '0, 32, '1);
      add_row(jtms_pkg::OP_READ_DR, ST_SDR, 0, '0, 1, 32'h0000_0001);
      add_row(jtms_pkg::OP_READ_DR, ST_UDR, 0, '1, 63, 32'hA5A5_A5A5);
      add_row(jtms_pkg::OP_READ_DR, ST_E2I, 0, '0, 0, '1);
      add_row(jtms_pkg::OP_GOTO, ST_E2D, 0, '0, 0, '0);
      add_row(jtms_pkg::OP_WRITE_DR, ST_TLR, 0, 32'h0000_001F, 5, '0);
      add_row(jtms_pkg::OP_GOTO, ST_CDR, 0, '0, 0, '0);
      add_row(OP_UNUSED_7, ST_SIS, 0, '0, 0, '0);
      add_row(jtms_pkg::OP_RESET, ST_TLR, 63, '1, 63, '1);
      n_dir = directed_rows.size();

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      for (int k = 0; k < n_dir + RANDOM_ITEMS; k++) begin
         calm = ((k / 45) % 4) == 3;
         gap  = calm ? 0 : pick_gap();
         // Hold off until every tick of earlier commands is back
         if (k == n_dir || k == n_dir + RANDOM_ITEMS / 2) begin
            req_chan.valid <= 1'b0;
            do @(posedge clock); while (tick_expect_q.size() != 0);
         end else if (gap > 0) begin
            req_chan.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         cmd = (k < n_dir) ? directed_rows[k].cmd : random_cmd();
         req_chan.valid        <= 1'b1;
         req_chan.op           <= cmd.op;
         req_chan.goal_state   <= cmd.target;
         req_chan.clock_count  <= cmd.clocks;
         req_chan.shift_data   <= cmd.data;
         req_chan.bit_count    <= cmd.nbits;
         req_chan.target_tdo   <= cmd.tdo;
         do @(posedge clock); while (!req_chan.ready);
         // Request taken at this edge: queue up its ticks
         predict_command(cmd);
         if (k < n_dir && directed_rows[k].typed) begin
            tick_expect_q.push_back(directed_rows[k].want);
         end else begin
            foreach (tick_plan[i]) tick_expect_q.push_back(tick_plan[i]);
         end
      end
      req_chan.valid <= 1'b0;
      calm = 1'b0;

      while (tick_expect_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && tick_expect_q.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/jtms_pkg.sv
hw/rtl/jtms_if.sv
hw/rtl/jtms_urom.sv
hw/rtl/jtms_seq.sv
hw/rtl/jtms_dp.sv
hw/rtl/jtag_master_tap_sequencer_unit.sv
bench/jtag_master_tap_sequencer_unit_tb.sv
